### src/tpbt_pkg.sv
package tpbt_pkg;

   localparam int ADDR_W    = 64;
   localparam int TAG_W     = 32;
   localparam int CSR_W     = 6;
   localparam int CSR_IDX_W = 2;
   localparam int SHIFT_W   = 3;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_UPDATE = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAGGED_MODE = 2'd0,
      CSR_TAG_WIDTH   = 2'd1,
      CSR_INST_SHIFT  = 2'd2
   } csr_index_type;

endpackage

### src/tpbt_if.sv
interface tpbt_req_if import tpbt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        op;
   logic [ADDR_W-1:0] addr;
   logic              prio_bit;

   modport source (output valid, op, addr, prio_bit, input ready);
   modport sink   (input valid, op, addr, prio_bit, output ready);
endinterface

interface tpbt_rsp_if ();
   logic valid;
   logic ready;
   logic prio_out;
   logic hit;

   modport source (output valid, prio_out, hit, input ready);
   modport sink   (input valid, prio_out, hit, output ready);
endinterface

### src/tagged_priority_bit_table.sv
// Channel   Dir  Handshake     Payload
// req_chan  in   valid/ready   op[1:0], addr[63:0], prio_bit
// rsp_chan  out  valid/ready   prio_out, hit
// csr_*     in   csr_we        csr_index[1:0], csr_wdata[5:0]
//
// Takes one request per cycle while the response is not stalled; each request's
// response passes the input register with row read, then the response register.
// The row store has one write and one read port; valid and written flags are
// flip-flops, so a clear drops them all at once with no sweep.
// Reset is synchronous, active high, clears control state and flags.
// A stalled response holds the request stage; new requests wait only then.
module tagged_priority_bit_table import tpbt_pkg::*; #(
   parameter int ENTRIES        = 64,
   parameter int BITS_PER_ENTRY = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   tpbt_req_if.sink             req_chan,
   tpbt_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // floor(log2) of the parameters: unused top entries or bits are never reached
   localparam int OFF_BITS = $clog2(BITS_PER_ENTRY + 1) - 1;
   localparam int IDX_BITS = $clog2(ENTRIES + 1) - 1;
   localparam int OFF_W    = (OFF_BITS > 0) ? OFF_BITS : 1;
   localparam int IDX_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
   localparam int VEC      = 1 << OFF_BITS;
   localparam int ROWS     = 1 << IDX_W;
   localparam int TAG_POS  = OFF_BITS + IDX_BITS;
   localparam int ROW_W    = TAG_W + VEC;

   // configuration registers
   logic               tagged_ff;
   logic [CSR_W-1:0]   tag_width_ff;
   logic [SHIFT_W-1:0] inst_shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tagged_ff     <= 1'b1;
         tag_width_ff  <= CSR_W'(16);
         inst_shift_ff <= SHIFT_W'(2);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TAGGED_MODE: tagged_ff     <= csr_wdata[0];
            CSR_TAG_WIDTH:   tag_width_ff  <= csr_wdata;
            CSR_INST_SHIFT:  inst_shift_ff <= csr_wdata[SHIFT_W-1:0];
            default: ;  // writes beyond the register list drop
         endcase
      end
   end

   // split the incoming address: drop inst_shift bits, then offset, index, tag
   logic [ADDR_W-1:0] addr_sh;
   logic [CSR_W-1:0]  tw_sat;
   logic [TAG_W-1:0]  tag_mask;
   logic [OFF_W-1:0]  off_in;
   logic [IDX_W-1:0]  idx_in;
   logic [TAG_W-1:0]  tag_in;

   always_comb begin
      addr_sh  = req_chan.addr >> inst_shift_ff;
      tw_sat   = (tag_width_ff > CSR_W'(TAG_W)) ? CSR_W'(TAG_W) : tag_width_ff;
      tag_mask = TAG_W'(({1'b0, {TAG_W{1'b0}}} | (33'd1 << tw_sat)) - 33'd1);
      off_in   = (OFF_BITS == 0) ? '0 : addr_sh[OFF_W-1:0];
      idx_in   = (IDX_BITS == 0) ? '0 : addr_sh[OFF_BITS +: IDX_W];
      tag_in   = addr_sh[TAG_POS +: TAG_W] & tag_mask;
   end

   // request stage
   logic             s1_valid_ff, s1_valid_in;
   logic [1:0]       s1_op_ff;
   logic [OFF_W-1:0] s1_off_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic [TAG_W-1:0] s1_tag_ff;
   logic             s1_pbit_ff;

   // response register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_prio_ff;
   logic rsp_hit_ff;

   // per-row flags: valid for tag matching, live for "bits written since clear"
   logic [ROWS-1:0] valid_ff, valid_in;
   logic [ROWS-1:0] live_ff, live_in;

   logic             req_ready;
   logic             req_fire;
   logic             s1_go;
   logic [ROW_W-1:0] rd_row;
   logic [ROW_W-1:0] wr_row;
   logic             wr_en;

   logic [VEC-1:0]   old_bits;
   logic [TAG_W-1:0] old_tag;
   logic [VEC-1:0]   new_bits;
   logic             is_lookup, is_update, is_clear;
   logic             match;
   logic             install;
   logic             prio_res, hit_res;

   // advance the request stage whenever the response register frees up
   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign req_fire  = req_chan.valid && req_ready;

   assign req_chan.ready    = req_ready;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.prio_out = rsp_prio_ff;
   assign rsp_chan.hit      = rsp_hit_ff;

   tpbt_store #(
      .ADDR_BITS (IDX_W),
      .DATA_BITS (ROW_W)
   ) u_store (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (idx_in),
      .wr_en   (wr_en),
      .wr_addr (s1_idx_ff),
      .wr_data (wr_row),
      .rd_data (rd_row)
   );

   always_comb begin
      is_lookup = (s1_op_ff == OP_LOOKUP);
      is_update = (s1_op_ff == OP_UPDATE);
      is_clear  = (s1_op_ff == OP_CLEAR);

      // a row untouched since the last clear reads as all zero
      old_bits = live_ff[s1_idx_ff] ? rd_row[VEC-1:0] : '0;
      old_tag  = rd_row[ROW_W-1 -: TAG_W];

      match   = tagged_ff ? (valid_ff[s1_idx_ff] && (old_tag == s1_tag_ff)) : 1'b1;
      install = tagged_ff && !match;

      // a miss starts from a clean vector, then the one bit is written
      new_bits            = match ? old_bits : '0;
      new_bits[s1_off_ff] = s1_pbit_ff;

      prio_res = 1'b0;
      hit_res  = 1'b0;
      if (is_lookup) begin
         hit_res  = match;
         prio_res = match && old_bits[s1_off_ff];
      end else if (is_update) begin
         hit_res  = match;
         prio_res = s1_pbit_ff;
      end

      wr_en  = s1_go && is_update;
      wr_row = {install ? s1_tag_ff : old_tag, new_bits};

      valid_in = valid_ff;
      live_in  = live_ff;
      if (s1_go) begin
         if (is_clear) begin
            valid_in = '0;
            live_in  = '0;
         end else if (is_update) begin
            live_in[s1_idx_ff] = 1'b1;
            if (install) begin
               valid_in[s1_idx_ff] = 1'b1;
            end
         end
      end

      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         live_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         live_ff      <= live_in;
      end
   end

   // payload registers: load the request on accept, the response on advance
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff   <= req_chan.op;
         s1_off_ff  <= off_in;
         s1_idx_ff  <= idx_in;
         s1_tag_ff  <= tag_in;
         s1_pbit_ff <= req_chan.prio_bit;
      end
      if (s1_go) begin
         rsp_prio_ff <= prio_res;
         rsp_hit_ff  <= hit_res;
      end
   end

   // a tag-valid row always has its bits written since the last clear
   a_valid_implies_live: assert property (@(posedge clock) disable iff (reset)
      (valid_ff & ~live_ff) == '0)
      else $error("valid row without live bits");

   // a processed clear leaves no row flagged
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (s1_go && is_clear) |=> (live_ff == '0) && (valid_ff == '0))
      else $error("clear left flagged rows");

   // an update reports the bit it wrote
   a_update_echo: assert property (@(posedge clock) disable iff (reset)
      (s1_go && is_update) |=> (rsp_prio_ff == $past(s1_pbit_ff)))
      else $error("update response does not echo written bit");

   // untagged lookups and updates always hit
   a_untagged_hit: assert property (@(posedge clock) disable iff (reset)
      (s1_go && !tagged_ff && (is_lookup || is_update)) |=> rsp_hit_ff)
      else $error("untagged access missed");

   // requests are refused only while a response is stalled behind a full stage
   a_ready_only_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_chan.ready))
      else $error("request refused without a stall");

endmodule

### src/tpbt_store.sv
module tpbt_store #(
   parameter int ADDR_BITS = 6,
   parameter int DATA_BITS = 48
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   output logic [DATA_BITS-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // a read that collides with this cycle's write returns the new row
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import tpbt_pkg::*;

   localparam int ENTRIES        = 64;
   localparam int BITS_PER_ENTRY = 16;
   localparam int OFF_BITS       = $clog2(BITS_PER_ENTRY);
   localparam int IDX_BITS       = $clog2(ENTRIES);

   // Codes with no meaning to the block; both must be tolerated.
   localparam logic [1:0]           OP_RESERVED  = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED = 2'd3;

   localparam int POOL_SIZE    = 8;
   localparam int HOLD_AFTER   = 200;   // requests taken before the long hold-off
   localparam int HOLD_CYCLES  = 300;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [1:0]        op;
      logic [ADDR_W-1:0] addr;
      logic              prio_bit;
   } table_access_type;

   typedef struct packed {
      logic prio_out;
      logic hit;
   } access_result_type;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   tpbt_req_if req_bus ();
   tpbt_rsp_if rsp_bus ();

   tagged_priority_bit_table #(
      .ENTRIES        (ENTRIES),
      .BITS_PER_ENTRY (BITS_PER_ENTRY)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the table and its settings; the table advances once per accepted request.
   logic                      shadow_tagged;
   logic [CSR_W-1:0]          shadow_tag_width;
   logic [SHIFT_W-1:0]        shadow_inst_shift;
   logic                      row_valid [ENTRIES];
   logic [TAG_W-1:0]          row_tag   [ENTRIES];
   logic [BITS_PER_ENTRY-1:0] row_vec   [ENTRIES];

   table_access_type  pending_accesses [$];
   access_result_type expected_results [$];
   logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

   table_access_type next_access;
   access_result_type want;
   int  send_gap;
   int  recv_stall;
   int  requests_taken = 0;
   int  mismatch_count = 0;
   logic hold_off;
   logic no_gaps;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one; none at all while no_gaps is set.
   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (no_gaps)
         return 0;
      if (roll < 50)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Work out what one access returns and apply its effect to the shadow table.
   function automatic access_result_type predict_access(logic [1:0] op,
                                                        logic [ADDR_W-1:0] addr,
                                                        logic prio_bit);
      int unsigned s_idx, s_tag, tw, off, idx;
      logic [TAG_W-1:0] tag;
      access_result_type res;
      s_idx = shadow_inst_shift + OFF_BITS;
      s_tag = s_idx + IDX_BITS;
      tw    = (shadow_tag_width > TAG_W) ? TAG_W : shadow_tag_width;
      off   = int'((addr >> shadow_inst_shift) & 64'(BITS_PER_ENTRY - 1));
      idx   = int'((addr >> s_idx) & 64'(ENTRIES - 1));
      tag   = TAG_W'((addr >> s_tag) & ((64'd1 << tw) - 64'd1));
      res   = '0;
      if (op == OP_LOOKUP || op == OP_UPDATE) begin
         // untagged mode never looks at valid marks or tags
         res.hit = shadow_tagged ? (row_valid[idx] && row_tag[idx] == tag) : 1'b1;
         if (op == OP_LOOKUP) begin
            res.prio_out = res.hit & row_vec[idx][off];
         end else begin
            if (!res.hit) begin
               // install: take the tag, wipe the vector
               row_valid[idx] = 1'b1;
               row_tag[idx]   = tag;
               row_vec[idx]   = '0;
            end
            row_vec[idx][off] = prio_bit;
            res.prio_out      = prio_bit;
         end
      end else if (op == OP_CLEAR) begin
         // tags survive a clear; only valid marks and bits drop
         foreach (row_valid[i]) begin
            row_valid[i] = 1'b0;
            row_vec[i]   = '0;
         end
      end
      return res;
   endfunction

   // Random access: mostly reuse pool addresses so lookups and updates hit,
   // with fresh noise in every bit that does not pick the entry or tag.
   function automatic table_access_type random_access();
      table_access_type acc;
      int unsigned roll, slot, s_idx, tw;
      logic [ADDR_W-1:0] keep, noise, base;
      s_idx = shadow_inst_shift + OFF_BITS;
      tw    = (shadow_tag_width > TAG_W) ? TAG_W : shadow_tag_width;
      keep  = ((64'd1 << (IDX_BITS + tw)) - 64'd1) << s_idx;
      noise = {$urandom, $urandom};
      roll  = $urandom_range(0, 99);
      slot  = $urandom_range(0, POOL_SIZE - 1);
      if (roll < 10) begin
         base = {$urandom, $urandom};
         // crowd half the fresh bases into a few entries to force evictions
         if ($urandom_range(0, 1))
            base = (base & ~(64'(ENTRIES - 1) << s_idx)) | (64'($urandom_range(0, 3)) << s_idx);
         addr_pool[slot] = base;
      end
      if (roll < 75)
         acc.addr = (addr_pool[slot] & keep) | (noise & ~keep);
      else
         acc.addr = noise;
      roll = $urandom_range(0, 99);
      if (roll < 47)
         acc.op = OP_LOOKUP;
      else if (roll < 96)
         acc.op = OP_UPDATE;
      else if (roll < 98)
         acc.op = OP_CLEAR;
      else
         acc.op = OP_RESERVED;
      acc.prio_bit = 1'($urandom_range(0, 1));
      return acc;
   endfunction

   task automatic queue_access(logic [1:0] op, logic [ADDR_W-1:0] addr, logic prio_bit);
      table_access_type acc;
      acc.op       = op;
      acc.addr     = addr;
      acc.prio_bit = prio_bit;
      pending_accesses.push_back(acc);
   endtask

   task automatic queue_random(int count);
      for (int n = 0; n < count; n++)
         pending_accesses.push_back(random_access());
   endtask

   // Hold until every queued request went in and every response came out.
   task automatic drain_traffic();
      while (pending_accesses.size() != 0 || req_bus.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register write; the shadow settings follow at once since the block is idle.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_TAGGED_MODE)
         shadow_tagged = data[0];
      else if (idx == CSR_TAG_WIDTH)
         shadow_tag_width = data;
      else if (idx == CSR_INST_SHIFT)
         shadow_inst_shift = data[SHIFT_W-1:0];
   endtask

   task automatic program_regs(logic [CSR_W-1:0] mode_w, logic [CSR_W-1:0] width_w,
                               logic [CSR_W-1:0] shift_w);
      write_reg(CSR_TAGGED_MODE, mode_w);
      write_reg(CSR_TAG_WIDTH, width_w);
      write_reg(CSR_INST_SHIFT, shift_w);
   endtask

   task automatic note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch at %0t: %s", $time, msg);
   endtask

   // Request driver: advance to the next request once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap      <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap != 0) begin
            send_gap      <= send_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_accesses.size() != 0) begin
            next_access = pending_accesses.pop_front();
            req_bus.op       <= next_access.op;
            req_bus.addr     <= next_access.addr;
            req_bus.prio_bit <= next_access.prio_bit;
            req_bus.valid    <= 1'b1;
            send_gap         <= pick_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response sink: random stalls, plus the long hold-off when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_stall    <= 0;
      end else if (recv_stall != 0) begin
         recv_stall    <= recv_stall - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !hold_off;
         recv_stall    <= pick_gap();
      end
   end

   // Monitor: predict on each accepted request, check each accepted response.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            expected_results.push_back(predict_access(req_bus.op, req_bus.addr,
                                                      req_bus.prio_bit));
            requests_taken <= requests_taken + 1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               note_mismatch($sformatf("response with nothing outstanding: prio_out=%b hit=%b",
                                       rsp_bus.prio_out, rsp_bus.hit));
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.prio_out !== want.prio_out)
                  note_mismatch($sformatf("prio_out expected %b got %b",
                                          want.prio_out, rsp_bus.prio_out));
               if (rsp_bus.hit !== want.hit)
                  note_mismatch($sformatf("hit expected %b got %b", want.hit, rsp_bus.hit));
            end
         end
      end
   end

   // Long hold-off on the response side while requests keep coming, so the
   // block backs up and has to stall its input.
   initial begin
      hold_off = 1'b0;
      while (requests_taken < HOLD_AFTER)
         @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #10_000_000;
      $display("testbench: errors");
      $finish;
   end

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.op       = '0;
      req_bus.addr     = '0;
      req_bus.prio_bit = 1'b0;
      rsp_bus.ready    = 1'b0;
      no_gaps          = 1'b0;
      send_gap         = 0;
      recv_stall       = 0;
      shadow_tagged     = 1'b1;
      shadow_tag_width  = 6'd16;
      shadow_inst_shift = 3'd2;
      foreach (row_valid[i]) begin
         row_valid[i] = 1'b0;
         row_tag[i]   = '0;
         row_vec[i]   = '0;
      end
      foreach (addr_pool[i])
         addr_pool[i] = {$urandom, $urandom};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: tagged, 16-bit tags, shift of 2.
      queue_access(OP_LOOKUP, 64'h0, 1'b0);                  // empty table misses
      queue_access(OP_UPDATE, 64'h0, 1'b1);                  // install on miss
      queue_access(OP_LOOKUP, 64'h0, 1'b0);
      queue_access(OP_LOOKUP, 64'h3C, 1'b0);                 // top offset, same entry
      queue_access(OP_UPDATE, 64'h1000, 1'b0);               // other tag evicts entry 0
      queue_access(OP_LOOKUP, 64'h0, 1'b0);
      queue_access(OP_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      queue_access(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      queue_access(OP_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0); // rewrite on a hit
      queue_access(OP_LOOKUP, 64'h0000_0000_0FFF_FFFF, 1'b0); // bits above the tag ignored
      queue_access(OP_RESERVED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      queue_access(OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      queue_access(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0); // cleared entry misses
      queue_access(OP_UPDATE, 64'h8000_0000_0000_0000, 1'b1);
      queue_access(OP_UPDATE, 64'h8000_0000_0000_003C, 1'b1);
      queue_access(OP_LOOKUP, 64'h8000_0000_0000_0000, 1'b0);
      queue_random(600);

      // Untagged mode, zero tag width, no shift.
      drain_traffic();
      program_regs(6'd0, 6'd0, 6'd0);
      queue_access(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      queue_access(OP_UPDATE, 64'h5, 1'b1);
      queue_access(OP_LOOKUP, 64'h5, 1'b0);
      queue_access(OP_CLEAR, 64'h0, 1'b0);
      queue_access(OP_LOOKUP, 64'h5, 1'b0);                  // still hits, bit cleared
      queue_random(200);

      // Tagged again with saturated tag width and the widest shift.
      drain_traffic();
      program_regs(6'd1, 6'd63, 6'd7);
      queue_random(200);

      // One-bit tags, shift of 4, back-to-back traffic.
      drain_traffic();
      no_gaps <= 1'b1;
      program_regs(6'd1, 6'd1, 6'd4);
      queue_random(200);

      // Upper data bits on the mode register must not matter; poke the unused index.
      drain_traffic();
      no_gaps <= 1'b0;
      program_regs(6'b101010, 6'd32, 6'd5);
      write_reg(CSR_RESERVED, 6'b111111);
      queue_random(200);

      drain_traffic();
      program_regs(6'b010101, 6'd33, 6'd3);
      queue_random(200);

      // A few settings drawn at random over the whole data width.
      for (int p = 0; p < 3; p++) begin
         drain_traffic();
         program_regs(CSR_W'($urandom_range(0, 63)), CSR_W'($urandom_range(0, 63)),
                      CSR_W'($urandom_range(0, 63)));
         queue_random(100);
      end

      drain_traffic();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
